>>> hw/rtl/pal_pkg.sv
package pal_pkg;

  localparam int DataW   = 32;
  localparam int RegNumW = 4;
  localparam int RegNums = 2 ** RegNumW;

  typedef logic [DataW-1:0]   data_t;
  typedef logic [RegNumW-1:0] regnum_t;

  typedef enum logic [2:0] {
    KindBubble = 3'd0,
    KindMov    = 3'd1,
    KindAdd    = 3'd2,
    KindSub    = 3'd3,
    KindMul    = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    FromNone  = 2'd0,
    FromRf    = 2'd1,
    FromExMem = 2'd2,
    FromMemWb = 2'd3
  } from_e;

  typedef struct packed {
    logic    valid;
    kind_e   kind;
    regnum_t dest;
    regnum_t src_a;
    regnum_t src_b;
    data_t   imm;
  } instr_t;

  typedef struct packed {
    logic    valid;
    regnum_t dest;
    data_t   result;
  } result_t;

endpackage

>>> hw/rtl/pal_regfile.sv
module pal_regfile import pal_pkg::*; #(
  parameter int REG_COUNT = 16,
  parameter int RfIdxW    = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              wr_en_i,
  input  logic [RfIdxW-1:0] wr_addr_i,
  input  data_t             wr_data_i,
  input  logic [RfIdxW-1:0] rd_a_addr_i,
  input  logic [RfIdxW-1:0] rd_b_addr_i,
  output data_t             rd_a_data_o,
  output data_t             rd_b_data_o
);

  data_t                mem_q [REG_COUNT];
  logic [REG_COUNT-1:0] written_q;
  data_t                rd_a_raw_q, rd_b_raw_q, byp_data_q;
  logic                 vld_a_q, vld_b_q, byp_a_q, byp_b_q;

  always_ff @(posedge clk_i) begin
    if (en_i && wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (en_i) begin
      rd_a_raw_q <= mem_q[rd_a_addr_i];
      rd_b_raw_q <= mem_q[rd_b_addr_i];
      byp_data_q <= wr_data_i;
    end
  end

  // entries never written since reset read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
      vld_a_q   <= 1'b0;
      vld_b_q   <= 1'b0;
      byp_a_q   <= 1'b0;
      byp_b_q   <= 1'b0;
    end else if (en_i) begin
      if (wr_en_i) begin
        written_q[wr_addr_i] <= 1'b1;
      end
      vld_a_q <= written_q[rd_a_addr_i];
      vld_b_q <= written_q[rd_b_addr_i];
      byp_a_q <= wr_en_i && (wr_addr_i == rd_a_addr_i);
      byp_b_q <= wr_en_i && (wr_addr_i == rd_b_addr_i);
    end
  end

  assign rd_a_data_o = byp_a_q ? byp_data_q : (vld_a_q ? rd_a_raw_q : '0);
  assign rd_b_data_o = byp_b_q ? byp_data_q : (vld_b_q ? rd_b_raw_q : '0);

endmodule

>>> hw/rtl/pal_execute.sv
module pal_execute import pal_pkg::*; (
  input  instr_t  id_ex_i,
  input  result_t ex_mem_i,
  input  result_t mem_wb_i,
  input  data_t   rf_a_i,
  input  data_t   rf_b_i,
  output result_t executed_o,
  output from_e   from_a_o,
  output from_e   from_b_o
);

  data_t opnd_a, opnd_b;
  from_e src_a, src_b;

  // operand forwarding, youngest first
  always_comb begin
    if (ex_mem_i.valid && (ex_mem_i.dest == id_ex_i.src_a)) begin
      opnd_a = ex_mem_i.result;
      src_a  = FromExMem;
    end else if (mem_wb_i.valid && (mem_wb_i.dest == id_ex_i.src_a)) begin
      opnd_a = mem_wb_i.result;
      src_a  = FromMemWb;
    end else begin
      opnd_a = rf_a_i;
      src_a  = FromRf;
    end
    if (ex_mem_i.valid && (ex_mem_i.dest == id_ex_i.src_b)) begin
      opnd_b = ex_mem_i.result;
      src_b  = FromExMem;
    end else if (mem_wb_i.valid && (mem_wb_i.dest == id_ex_i.src_b)) begin
      opnd_b = mem_wb_i.result;
      src_b  = FromMemWb;
    end else begin
      opnd_b = rf_b_i;
      src_b  = FromRf;
    end
  end

  always_comb begin
    executed_o.valid  = id_ex_i.valid;
    executed_o.dest   = id_ex_i.dest;
    executed_o.result = '0;
    from_a_o          = FromNone;
    from_b_o          = FromNone;
    if (id_ex_i.valid) begin
      if (id_ex_i.kind == KindMov) begin
        executed_o.result = id_ex_i.imm;
      end else begin
        from_a_o = src_a;
        from_b_o = src_b;
        case (id_ex_i.kind)
          KindAdd: executed_o.result = data_t'(opnd_a + opnd_b);
          KindSub: executed_o.result = data_t'(opnd_a - opnd_b);
          KindMul: executed_o.result = data_t'(opnd_a * opnd_b);
          default: executed_o.result = '0;
        endcase
      end
    end
  end

endmodule

>>> hw/rtl/pipelined_alu_with_forwarding.sv
// Five-stage in-order pipeline (fetch, decode, execute, memory, write-back) with full
// forwarding for mov-immediate, add, sub and mul on REG_COUNT 32-bit registers. Every
// accepted item is one clock tick of the pipeline and carries the instruction fetched in
// that tick; bubbles (kind 0, or kinds 5 to 7) drain it. Each item yields exactly one
// result item, held in an output register and visible the cycle after acceptance: it
// reports the instruction executing in that tick (accepted two items earlier), the source
// of each operand, and any write-back (from the instruction accepted four items earlier).
// The block takes one item per cycle while the output register is not full and stalled;
// execute is combinational, forwarding muxes then one 32x32 multiplier feeding the result
// register. The register file reads zero after reset through per-entry written flags,
// so no clearing pass is needed. Register numbers are reduced modulo REG_COUNT.
module pipelined_alu_with_forwarding import pal_pkg::*; #(
  parameter int REG_COUNT = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [2:0]          kind_i,
  input  logic [RegNumW-1:0]  dest_reg_i,
  input  logic [RegNumW-1:0]  src_a_reg_i,
  input  logic [RegNumW-1:0]  src_b_reg_i,
  input  logic signed [31:0]  immediate_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                ex_active_o,
  output logic signed [31:0]  ex_result_o,
  output logic [1:0]          src_a_from_o,
  output logic [1:0]          src_b_from_o,
  output logic                wb_write_o,
  output logic [RegNumW-1:0]  wb_reg_o,
  output logic signed [31:0]  wb_value_o
);

  localparam int RfIdxW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

  regnum_t reg_mod [RegNums];
  for (genvar g = 0; g < RegNums; g++) begin : g_mod
    assign reg_mod[g] = RegNumW'(g % REG_COUNT);
  end

  logic    accept;
  logic    kind_ok;
  instr_t  fetched;
  instr_t  if_id_q, id_ex_q;
  result_t ex_mem_q, mem_wb_q, executed;
  data_t   rf_a, rf_b;
  from_e   from_a, from_b;
  logic    out_valid_q;
  logic    ex_active_q, wb_write_q;
  data_t   ex_result_q, wb_value_q;
  from_e   src_a_from_q, src_b_from_q;
  regnum_t wb_reg_q;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  // decode of the fetched instruction
  assign kind_ok       = (kind_i >= 3'(KindMov)) && (kind_i <= 3'(KindMul));
  assign fetched.valid = kind_ok;
  assign fetched.kind  = kind_ok ? kind_e'(kind_i) : KindBubble;
  assign fetched.dest  = reg_mod[dest_reg_i];
  assign fetched.src_a = reg_mod[src_a_reg_i];
  assign fetched.src_b = reg_mod[src_b_reg_i];
  assign fetched.imm   = data_t'(immediate_i);

  pal_regfile #(
    .REG_COUNT (REG_COUNT)
  ) u_regfile (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (accept),
    .wr_en_i     (mem_wb_q.valid),
    .wr_addr_i   (RfIdxW'(mem_wb_q.dest)),
    .wr_data_i   (mem_wb_q.result),
    .rd_a_addr_i (RfIdxW'(if_id_q.src_a)),
    .rd_b_addr_i (RfIdxW'(if_id_q.src_b)),
    .rd_a_data_o (rf_a),
    .rd_b_data_o (rf_b)
  );

  pal_execute u_execute (
    .id_ex_i    (id_ex_q),
    .ex_mem_i   (ex_mem_q),
    .mem_wb_i   (mem_wb_q),
    .rf_a_i     (rf_a),
    .rf_b_i     (rf_b),
    .executed_o (executed),
    .from_a_o   (from_a),
    .from_b_o   (from_b)
  );

  // pipeline latches advance once per accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      if_id_q  <= '0;
      id_ex_q  <= '0;
      ex_mem_q <= '0;
      mem_wb_q <= '0;
    end else if (accept) begin
      if_id_q  <= fetched;
      id_ex_q  <= if_id_q;
      ex_mem_q <= executed;
      mem_wb_q <= ex_mem_q;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ex_active_q  <= executed.valid;
      ex_result_q  <= executed.result;
      src_a_from_q <= from_a;
      src_b_from_q <= from_b;
      wb_write_q   <= mem_wb_q.valid;
      wb_reg_q     <= mem_wb_q.valid ? mem_wb_q.dest : '0;
      wb_value_q   <= mem_wb_q.valid ? mem_wb_q.result : '0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign ex_active_o  = ex_active_q;
  assign ex_result_o  = ex_result_q;
  assign src_a_from_o = src_a_from_q;
  assign src_b_from_o = src_b_from_q;
  assign wb_write_o   = wb_write_q;
  assign wb_reg_o     = wb_reg_q;
  assign wb_value_o   = wb_value_q;

  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted item gave no result");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with output register free");

  a_bubble_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ex_active_o |->
      ex_result_o == '0 && src_a_from_o == FromNone && src_b_from_o == FromNone)
    else $error("bubble in execute reported activity");

  a_no_wb_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !wb_write_o |-> wb_reg_o == '0 && wb_value_o == '0)
    else $error("write-back fields set without a write");

endmodule

>>> tb/tb_pipelined_alu_with_forwarding.sv
module tb_pipelined_alu_with_forwarding;
  import pal_pkg::*;

  typedef struct packed {
    logic    ex_active;
    data_t   ex_result;
    from_e   src_a_from;
    from_e   src_b_from;
    logic    wb_write;
    regnum_t wb_reg;
    data_t   wb_value;
  } tick_out_t;

  localparam int CycleLimit = 200000;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic [2:0]         kind_i      = '0;
  regnum_t            dest_reg_i  = '0;
  regnum_t            src_a_reg_i = '0;
  regnum_t            src_b_reg_i = '0;
  logic signed [31:0] immediate_i = '0;
  logic               out_stall_i = 1'b0;

  logic               in_stall_o;
  logic               out_valid_o;
  logic               ex_active_o;
  logic signed [31:0] ex_result_o;
  logic [1:0]         src_a_from_o;
  logic [1:0]         src_b_from_o;
  logic               wb_write_o;
  regnum_t            wb_reg_o;
  logic signed [31:0] wb_value_o;

  pipelined_alu_with_forwarding dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .dest_reg_i   (dest_reg_i),
    .src_a_reg_i  (src_a_reg_i),
    .src_b_reg_i  (src_b_reg_i),
    .immediate_i  (immediate_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .ex_active_o  (ex_active_o),
    .ex_result_o  (ex_result_o),
    .src_a_from_o (src_a_from_o),
    .src_b_from_o (src_b_from_o),
    .wb_write_o   (wb_write_o),
    .wb_reg_o     (wb_reg_o),
    .wb_value_o   (wb_value_o)
  );

  data_t     model_rf [RegNums];
  instr_t    model_fd = '0;
  instr_t    model_de = '0;
  result_t   model_em = '0;
  result_t   model_mw = '0;
  tick_out_t pending_results [$];
  int        fail_count    = 0;
  int        cycle_count   = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;

  initial begin
    for (int i = 0; i < RegNums; i++) model_rf[i] = '0;
  end

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void fetch_operand(input regnum_t r, output data_t v, output from_e f);
    if (model_em.valid && model_em.dest == r) begin
      v = model_em.result;
      f = FromExMem;
    end else if (model_mw.valid && model_mw.dest == r) begin
      v = model_mw.result;
      f = FromMemWb;
    end else begin
      v = model_rf[r];
      f = FromRf;
    end
  endfunction

  function automatic tick_out_t tick_pipeline(input logic [2:0] k, input regnum_t d,
                                              input regnum_t a, input regnum_t b,
                                              input data_t imm);
    tick_out_t o;
    data_t     va;
    data_t     vb;
    data_t     r;
    from_e     fa;
    from_e     fb;
    instr_t    fetched;
    result_t   executed;
    o = '0;
    executed = '0;
    if (model_mw.valid) begin
      model_rf[model_mw.dest] = model_mw.result;
      o.wb_write = 1'b1;
      o.wb_reg   = model_mw.dest;
      o.wb_value = model_mw.result;
    end
    if (model_de.valid) begin
      if (model_de.kind == KindMov) begin
        r = model_de.imm;
      end else begin
        fetch_operand(model_de.src_a, va, fa);
        fetch_operand(model_de.src_b, vb, fb);
        o.src_a_from = fa;
        o.src_b_from = fb;
        case (model_de.kind)
          KindAdd: r = va + vb;
          KindSub: r = va - vb;
          default: r = va * vb;
        endcase
      end
      executed.valid  = 1'b1;
      executed.dest   = model_de.dest;
      executed.result = r;
      o.ex_active = 1'b1;
      o.ex_result = r;
    end
    fetched.valid = (k >= KindMov) && (k <= KindMul);
    fetched.kind  = fetched.valid ? kind_e'(k) : KindBubble;
    fetched.dest  = d;
    fetched.src_a = a;
    fetched.src_b = b;
    fetched.imm   = imm;
    model_mw = model_em;
    model_em = executed;
    model_de = model_fd;
    model_fd = fetched;
    return o;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s expected %0h actual %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    tick_out_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          $error("result item with no expectation waiting");
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("ex_active", want.ex_active, ex_active_o);
          check_field("ex_result", want.ex_result, ex_result_o);
          check_field("src_a_from", want.src_a_from, src_a_from_o);
          check_field("src_b_from", want.src_b_from, src_b_from_o);
          check_field("wb_write", want.wb_write, wb_write_o);
          check_field("wb_reg", want.wb_reg, wb_reg_o);
          check_field("wb_value", want.wb_value, wb_value_o);
        end
      end
      if (in_valid_i && !in_stall_o) begin
        pending_results.push_back(tick_pipeline(kind_i, dest_reg_i, src_a_reg_i,
                                                src_b_reg_i, immediate_i));
      end
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("pipelined_alu_with_forwarding test failed");
      $finish;
    end
  end

  task automatic send_item(input logic [2:0] k, input regnum_t d, input regnum_t a,
                           input regnum_t b, input logic [31:0] imm);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    kind_i      <= k;
    dest_reg_i  <= d;
    src_a_reg_i <= a;
    src_b_reg_i <= b;
    immediate_i <= imm;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
  endtask

  // registers read straight after reset must be zero
  task automatic test_reset_reads();
    send_item(KindAdd, 4'd15, 4'd0, 4'd15, 32'h0);
    send_item(KindMul, 4'd0, 4'd15, 4'd15, 32'hffff_ffff);
  endtask

  // mov ignores its source fields
  task automatic test_mov_extremes();
    send_item(KindMov, 4'd1, 4'd15, 4'd15, 32'h7fff_ffff);
    send_item(KindMov, 4'd2, 4'd0, 4'd0, 32'h8000_0000);
    send_item(KindMov, 4'd3, 4'd1, 4'd2, 32'hffff_ffff);
    send_item(KindMov, 4'd4, 4'd3, 4'd3, 32'h0);
  endtask

  task automatic test_forwarding();
    send_item(KindMov, 4'd6, 4'd0, 4'd0, 32'd5);
    send_item(KindMul, 4'd7, 4'd6, 4'd6, 32'h0);
    send_item(KindSub, 4'd8, 4'd7, 4'd6, 32'h0);
    send_item(KindAdd, 4'd9, 4'd6, 4'd8, 32'h0);
    send_item(KindBubble, 4'd9, 4'd9, 4'd9, 32'h1234_5678);
    send_item(KindAdd, 4'd10, 4'd8, 4'd9, 32'h0);
  endtask

  task automatic test_wraparound();
    send_item(KindMul, 4'd11, 4'd1, 4'd1, 32'h0);
    send_item(KindSub, 4'd12, 4'd0, 4'd1, 32'h0);
    send_item(KindAdd, 4'd13, 4'd1, 4'd1, 32'h0);
    send_item(KindAdd, 4'd14, 4'd2, 4'd3, 32'h0);
  endtask

  // kinds above mul behave as bubbles
  task automatic test_unknown_kinds();
    send_item(3'd5, 4'd15, 4'd15, 4'd15, 32'hffff_ffff);
    send_item(3'd6, 4'd1, 4'd2, 4'd3, 32'h5555_5555);
    send_item(3'd7, 4'd15, 4'd15, 4'd15, 32'haaaa_aaaa);
    send_item(KindBubble, 4'd15, 4'd15, 4'd15, 32'hffff_ffff);
  endtask

  function automatic regnum_t pick_reg();
    return ($urandom_range(99) < 50) ? regnum_t'($urandom_range(3)) :
                                       regnum_t'($urandom_range(15));
  endfunction

  task automatic test_random(input int n);
    logic [2:0]  k;
    logic [31:0] imm;
    int          roll;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(99);
      if (roll < 75) k = 3'($urandom_range(1, 4));
      else if (roll < 92) k = KindBubble;
      else k = 3'($urandom_range(5, 7));
      roll = $urandom_range(99);
      case (1'b1)
        roll < 4:  imm = 32'h7fff_ffff;
        roll < 8:  imm = 32'h8000_0000;
        roll < 12: imm = 32'hffff_ffff;
        roll < 15: imm = 32'h0;
        roll < 35: imm = $urandom_range(20);
        default:   imm = $urandom();
      endcase
      send_item(k, pick_reg(), pick_reg(), pick_reg(), imm);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 12;
    recv_idle_pct = 67;
    test_reset_reads();
    test_mov_extremes();
    test_forwarding();
    test_wraparound();
    test_unknown_kinds();
    test_random(170);

    send_idle_pct = 67;
    recv_idle_pct = 12;
    test_random(170);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(170);
    repeat (4) send_item(KindBubble, 4'd0, 4'd0, 4'd0, 32'h0);
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("pipelined_alu_with_forwarding test passed");
    end else begin
      $display("pipelined_alu_with_forwarding test failed");
    end
    $finish;
  end

endmodule
